>>> rtl/puh_pkg.sv
package puh_pkg;

	localparam int DIMENSIONS    = 2;
	localparam int LEVELS        = 10;
	localparam int FRACTION_BITS = 32;

	localparam int POS_W   = FRACTION_BITS + 1;
	localparam int COORD_W = 16;
	localparam int DIM_W   = 3;

	// Ternary digits produced per pipeline stage, and the resulting depth.
	localparam int DIGITS           = DIMENSIONS * LEVELS;
	localparam int DIGITS_PER_STAGE = 2;
	localparam int STAGES           = (DIGITS + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [DIMENSIONS-1:0][COORD_W-1:0] coords_t;

	// Partial state of one position while its digits are being extracted.
	typedef struct packed {
		logic [FRACTION_BITS-1:0] rem;
		logic                     sat;
		logic                     total_par;
		logic [DIMENSIONS-1:0]    own_par;
		coords_t                  coord;
	} work_t;

	// Finished position handed to the output serializer.
	typedef struct packed {
		logic    valid;
		coords_t coord;
	} item_t;

endpackage

>>> rtl/puh_serial.sv
module puh_serial (
	input  logic            clk,
	input  logic            arst_n,
	input  puh_pkg::item_t  item,
	output logic            take,
	output logic            result_valid,
	input  logic            result_stall,
	output puh_pkg::coord_t coordinate,
	output logic [2:0]      dimension,
	output logic            last
);
	import puh_pkg::*;

	logic             busy_q;
	logic [DIM_W-1:0] cnt_q;
	coords_t          coord_q;

	assign last = (cnt_q == DIM_W'(DIMENSIONS - 1));

	// A new position is loaded when none is held, or once the final coordinate of the held one leaves.
	assign take = !busy_q || (!result_stall && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= item.valid;
			cnt_q  <= '0;
		end else if (!result_stall) begin
			cnt_q <= cnt_q + DIM_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			coord_q <= item.coord;
		end else if (!result_stall) begin
			coord_q <= coords_t'(coord_q >> COORD_W);
		end
	end

	assign result_valid = busy_q;
	assign coordinate   = coord_q[0];
	assign dimension    = cnt_q;

endmodule

>>> rtl/peano_unit_to_hypercube.sv
// Path: a position passes one register per two ternary digits, then the serializer
// register; its coordinates are offered one per cycle while result_stall is low.
// Throughput: one coordinate per cycle on the single result channel, stalls aside; a
// new position enters whenever the serializer takes one, with several in flight.
// Reset: arst_n clears the stage valid bits and the serializer; data needs no reset.
module peano_unit_to_hypercube (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	output logic                      stall,
	input  logic [puh_pkg::POS_W-1:0] position,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [15:0]               coordinate,
	output logic [2:0]                dimension,
	output logic                      last
);
	import puh_pkg::*;

	// Extract the digits base .. base+DIGITS_PER_STAGE-1 from a partial state.
	function automatic work_t step(input work_t w_in, input int base);
		work_t                  w;
		logic [FRACTION_BITS+1:0] s;
		logic [1:0]             d;
		logic                   flip;
		int                     k;
		w = w_in;
		for (int j = 0; j < DIGITS_PER_STAGE; j++) begin
			k = base + j;
			if (k < DIGITS) begin
				s = {2'b00, w.rem} + {1'b0, w.rem, 1'b0};
				if (w.sat) begin
					d = 2'd2;
				end else begin
					d     = s[FRACTION_BITS+1:FRACTION_BITS];
					w.rem = s[FRACTION_BITS-1:0];
				end
				w.total_par = w.total_par ^ d[0];
				for (int i = 0; i < DIMENSIONS; i++) begin
					if (i == k % DIMENSIONS) begin
						w.own_par[i] = w.own_par[i] ^ d[0];
						// Odd digit sum over the other dimensions reflects the digit.
						flip = w.total_par ^ w.own_par[i];
						if (flip) begin
							d = 2'd2 - d;
						end
						w.coord[i] = w.coord[i] + {w.coord[i][COORD_W-2:0], 1'b0}
							+ {{(COORD_W-2){1'b0}}, d};
					end
				end
			end
		end
		return w;
	endfunction

	logic        valid_s [STAGES];
	work_t       work_s  [STAGES];
	work_t       next_w  [STAGES];
	work_t       entry_w;
	logic        advance;
	item_t       item;

	always_comb begin
		entry_w           = '0;
		entry_w.sat       = position[FRACTION_BITS];
		entry_w.rem       = position[FRACTION_BITS] ? '0 : position[FRACTION_BITS-1:0];
	end

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			always_comb next_w[g] = step(entry_w, 0);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g] <= 1'b0;
				end else if (advance) begin
					valid_s[g] <= valid;
				end
			end
		end else begin : g_rest
			always_comb next_w[g] = step(work_s[g-1], g * DIGITS_PER_STAGE);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g] <= 1'b0;
				end else if (advance) begin
					valid_s[g] <= valid_s[g-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				work_s[g] <= next_w[g];
			end
		end
	end

	assign stall = !advance;

	assign item = {valid_s[STAGES-1], work_s[STAGES-1].coord};

	puh_serial u_serial (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.take         (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.coordinate   (coordinate),
		.dimension    (dimension),
		.last         (last)
	);

endmodule

>>> test/peano_unit_to_hypercube_tb.sv
`timescale 1ns / 1ps

module peano_unit_to_hypercube_tb;

	import puh_pkg::*;

	localparam int NUM_RANDOM     = 115;
	localparam int QUIET_ITEMS    = 20;
	localparam int HOLD_OFF_AT    = 20;
	localparam int HOLD_OFF_LEN   = 150;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam coord_t ALL_TWOS = 16'd59048;

	typedef struct {
		logic [POS_W-1:0] pos;
		bit               known;
		coords_t          want;
	} dir_row_t;

	typedef struct {
		coord_t     coord;
		logic [2:0] dim;
		logic       last;
	} coord_rec_t;

	localparam int NUM_DIR = 16;

	// Rows marked known carry the coordinates that follow straight from the digits:
	// zero and anything below 3^-20 give all zeros, one or more gives all twos.
	dir_row_t dir_rows [NUM_DIR] = '{
		'{33'h0_0000_0000, 1'b1, {16'd0, 16'd0}},
		'{33'h0_0000_0001, 1'b1, {16'd0, 16'd0}},
		'{33'h1_0000_0000, 1'b1, {ALL_TWOS, ALL_TWOS}},
		'{33'h1_FFFF_FFFF, 1'b1, {ALL_TWOS, ALL_TWOS}},
		'{33'h1_5A5A_A5A5, 1'b1, {ALL_TWOS, ALL_TWOS}},
		'{33'h0_FFFF_FFFF, 1'b0, '0},
		'{33'h0_8000_0000, 1'b0, '0},
		'{33'h0_5555_5555, 1'b0, '0},
		'{33'h0_5555_5556, 1'b0, '0},
		'{33'h0_AAAA_AAAA, 1'b0, '0},
		'{33'h0_AAAA_AAAB, 1'b0, '0},
		'{33'h0_0000_FFFF, 1'b0, '0},
		'{33'h0_FFFF_0000, 1'b0, '0},
		'{33'h0_3333_3333, 1'b0, '0},
		'{33'h0_CCCC_CCCC, 1'b0, '0},
		'{33'h0_0F0F_F0F0, 1'b0, '0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             valid = 1'b0;
	logic             stall;
	logic [POS_W-1:0] position = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic [15:0]      coordinate;
	logic [2:0]       dimension;
	logic             last;

	coord_rec_t coords_due [$];
	int         errors = 0;
	int         quiet_cycles = 0;
	bit         quiet_tail = 1'b0;
	bit         hold_off_now = 1'b0;

	peano_unit_to_hypercube i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid),
		.stall        (stall),
		.position     (position),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.coordinate   (coordinate),
		.dimension    (dimension),
		.last         (last)
	);

	always #5 clk = ~clk;

	// Expands the fraction into ternary digits and folds them into one coordinate
	// per dimension, reflecting a digit when the other dimensions sum to odd.
	function automatic coords_t peano_coords(input logic [POS_W-1:0] pos);
		logic [63:0] rem;
		logic [63:0] prod;
		logic [1:0]  dgt;
		int unsigned total;
		int unsigned own [DIMENSIONS];
		int          dm;
		logic        sat;
		coords_t     c;
		sat = pos[FRACTION_BITS];
		rem = sat ? 64'd0 : 64'(pos[FRACTION_BITS-1:0]);
		c = '0;
		total = 0;
		foreach (own[i])
			own[i] = 0;
		for (int k = 0; k < DIMENSIONS * LEVELS; k++) begin
			dm = k % DIMENSIONS;
			if (sat) begin
				dgt = 2'd2;
			end else begin
				prod = rem * 3;
				dgt = 2'(prod >> FRACTION_BITS);
				rem = prod & ((64'd1 << FRACTION_BITS) - 1);
			end
			total += dgt;
			own[dm] += dgt;
			if ((total - own[dm]) & 1)
				dgt = 2'd2 - dgt;
			c[dm] = coord_t'(c[dm] * 3 + dgt);
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic offer_position(input logic [POS_W-1:0] pos, input bit known,
			input coords_t want);
		coords_t    c;
		coord_rec_t rec;
		int         gap;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1'b1;
		position <= pos;
		@(posedge clk);
		while (stall)
			@(posedge clk);
		c = known ? want : peano_coords(pos);
		for (int i = 0; i < DIMENSIONS; i++) begin
			rec.coord = c[i];
			rec.dim = 3'(i);
			rec.last = (i == DIMENSIONS - 1);
			coords_due.push_back(rec);
		end
	endtask

	initial begin : stimulus
		logic [POS_W-1:0] pos;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[r])
			offer_position(dir_rows[r].pos, dir_rows[r].known, dir_rows[r].want);
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == HOLD_OFF_AT)
				hold_off_now = 1'b1;
			if (n == NUM_RANDOM - QUIET_ITEMS)
				quiet_tail = 1'b1;
			case ($urandom_range(0, 9))
				0: pos = {1'b1, 32'($urandom)};
				1: pos = 33'($urandom_range(0, 5000));
				2: pos = {1'b0, 32'hFFFF_FFFF - 32'($urandom_range(0, 5000))};
				default: pos = {1'b0, 32'($urandom)};
			endcase
			offer_position(pos, 1'b0, '0);
		end
		valid <= 1'b0;
		while (coords_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && coords_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Receiver pacing: random stall bursts, one long hold-off so the pipeline
	// fills and pushes back on the sender, and none once the tail begins.
	initial begin : sink_pacing
		int burst;
		wait (arst_n);
		while (!quiet_tail) begin
			@(posedge clk);
			if (hold_off_now) begin
				result_stall <= 1'b1;
				repeat (HOLD_OFF_LEN) @(posedge clk);
				hold_off_now = 1'b0;
				result_stall <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 17);
				result_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		coord_rec_t rec;
		if (arst_n && result_valid && !result_stall) begin
			if (coords_due.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction coord=%0d dim=%0d last=%0b",
					coordinate, dimension, last));
			end else begin
				rec = coords_due.pop_front();
				if (coordinate !== rec.coord)
					report_mismatch($sformatf("coordinate %0d, want %0d (dim %0d)",
						coordinate, rec.coord, rec.dim));
				if (dimension !== rec.dim)
					report_mismatch($sformatf("dimension %0d, want %0d", dimension, rec.dim));
				if (last !== rec.last)
					report_mismatch($sformatf("last %0b, want %0b (dim %0d)",
						last, rec.last, rec.dim));
			end
		end
	end

	always @(posedge clk) begin
		if ((valid && !stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
